// ----- hw/rtl/semu8_pkg.sv -----
package semu8_pkg;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [7:0]  LEAD2     = 8'hC0;
    localparam logic [7:0]  LEAD3     = 8'hE0;
    localparam logic [7:0]  CONT      = 8'h80;
    localparam logic [15:0] MAX_ONE   = 16'h007F;
    localparam logic [15:0] MAX_TWO   = 16'h07FF;
    localparam logic [7:0]  MASK_CONT = 8'h3F;
    localparam logic [7:0]  MASK_LEAD = 8'h1F;

    // Up to two characters to encode, then optionally the end beat.
    typedef struct packed {
        logic        has_a;
        logic [15:0] char_a;
        logic        has_b;
        logic [15:0] char_b;
        logic        has_end;
        logic        bad;
    } cmd_t;

    typedef struct packed {
        logic [1:0] len;
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
    } enc_t;

    function automatic enc_t encode(input logic [15:0] ch);
        enc_t e;
        e = '0;
        if (ch == 16'h0000)
        begin
            e.len = 2'd2;
            e.b0  = LEAD2;
            e.b1  = CONT;
        end
        else if (ch <= MAX_ONE)
        begin
            e.len = 2'd1;
            e.b0  = ch[7:0];
        end
        else if (ch <= MAX_TWO)
        begin
            e.len = 2'd2;
            e.b0  = LEAD2 | (ch[13:6] & MASK_LEAD);
            e.b1  = CONT | (ch[7:0] & MASK_CONT);
        end
        else
        begin
            e.len = 2'd3;
            e.b0  = LEAD3 | {4'h0, ch[15:12]};
            e.b1  = CONT | (ch[13:6] & MASK_CONT);
            e.b2  = CONT | (ch[7:0] & MASK_CONT);
        end
        return e;
    endfunction

endpackage

// ----- hw/rtl/semu8_ifs.sv -----
interface semu8_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        last_unit;
    logic        end_only;

    modport source (output valid, output code_unit, output last_unit, output end_only,
                    input ready);
    modport sink   (input valid, input code_unit, input last_unit, input end_only,
                    output ready);
endinterface

interface semu8_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       is_end;
    logic       is_bad;
    logic       run_last;

    modport source (output valid, output out_byte, output is_end, output is_bad,
                    output run_last, input ready);
    modport sink   (input valid, input out_byte, input is_end, input is_bad,
                    input run_last, output ready);
endinterface

// ----- hw/rtl/semu8_front.sv -----
module semu8_front (
    input  logic                clk,
    input  logic                rst_n,
    semu8_unit_if.sink          units,
    input  logic                full,
    output logic                push,
    output semu8_pkg::cmd_t     cmd
);

    typedef enum logic [3:0] {
        PH_TEXT = 4'b0001,
        PH_ESC  = 4'b0010,
        PH_OCT2 = 4'b0100,
        PH_OCT1 = 4'b1000
    } phase_t;

    localparam logic [15:0] CU_BACKSLASH = 16'h005C;
    localparam logic [15:0] CU_QUOTE     = 16'h0022;
    localparam logic [15:0] CU_APOS      = 16'h0027;
    localparam logic [15:0] CU_LF        = 16'h000A;
    localparam logic [15:0] CU_CR        = 16'h000D;
    localparam logic [15:0] CU_B         = 16'h0062;
    localparam logic [15:0] CU_F         = 16'h0066;
    localparam logic [15:0] CU_N         = 16'h006E;
    localparam logic [15:0] CU_R         = 16'h0072;
    localparam logic [15:0] CU_T         = 16'h0074;
    localparam logic [12:0] OCT_HIGH     = 13'h0006;

    phase_t     phase_reg, phase_next;
    logic [7:0] octal_reg, octal_next;
    logic       error_reg, error_next;

    logic        accept;
    logic        take;
    logic        ends;
    logic        is_oct;
    logic [2:0]  digit;
    logic        plain;
    logic        esc_ok;
    logic [15:0] esc_char;
    logic [15:0] u;

    assign units.ready = !full;
    assign accept      = units.valid && units.ready;
    assign u           = units.code_unit;
    assign take        = accept && !units.end_only && !error_reg;
    assign ends        = accept && (units.end_only || units.last_unit);
    assign is_oct      = (u[15:3] == OCT_HIGH);
    assign digit       = u[2:0];

    always_comb
    begin
        esc_ok   = 1'b1;
        esc_char = u;
        unique case (u)
            CU_B:         esc_char = 16'h0008;
            CU_F:         esc_char = 16'h000C;
            CU_N:         esc_char = CU_LF;
            CU_R:         esc_char = CU_CR;
            CU_T:         esc_char = 16'h0009;
            CU_QUOTE,
            CU_APOS,
            CU_BACKSLASH: esc_char = u;
            default:      esc_ok   = 1'b0;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        octal_next = octal_reg;
        error_next = error_reg;
        cmd        = '0;
        plain      = 1'b0;
        if (take)
        begin
            if (phase_reg == PH_OCT2 || phase_reg == PH_OCT1)
            begin
                if (is_oct)
                begin
                    octal_next = {octal_reg[4:0], digit};
                    if (phase_reg == PH_OCT2)
                    begin
                        phase_next = PH_OCT1;
                    end
                    else
                    begin
                        cmd.has_a  = 1'b1;
                        cmd.char_a = {8'h00, octal_reg[4:0], digit};
                        phase_next = PH_TEXT;
                    end
                end
                else
                begin
                    cmd.has_a  = 1'b1;
                    cmd.char_a = {8'h00, octal_reg};
                    phase_next = PH_TEXT;
                    plain      = 1'b1;
                end
            end
            else if (phase_reg == PH_ESC)
            begin
                priority if (is_oct)
                begin
                    octal_next = {5'b00000, digit};
                    phase_next = digit[2] ? PH_OCT1 : PH_OCT2;
                end
                else if (esc_ok)
                begin
                    cmd.has_a  = 1'b1;
                    cmd.char_a = esc_char;
                    phase_next = PH_TEXT;
                end
                else
                begin
                    error_next = 1'b1;
                    phase_next = PH_TEXT;
                end
            end
            else
            begin
                plain = 1'b1;
            end

            if (plain)
            begin
                priority if (u == CU_BACKSLASH)
                begin
                    phase_next = PH_ESC;
                end
                else if (u == CU_LF || u == CU_CR)
                begin
                    error_next = 1'b1;
                end
                else
                begin
                    cmd.has_b  = 1'b1;
                    cmd.char_b = u;
                end
            end
        end

        if (ends)
        begin
            if (!error_next)
            begin
                if (phase_next == PH_OCT2 || phase_next == PH_OCT1)
                begin
                    cmd.has_a  = 1'b1;
                    cmd.char_a = {8'h00, octal_next};
                end
                else if (phase_next == PH_ESC)
                begin
                    error_next = 1'b1;
                end
            end
            cmd.has_end = 1'b1;
            cmd.bad     = error_next;
            phase_next  = PH_TEXT;
            octal_next  = 8'h00;
            error_next  = 1'b0;
        end
    end

    assign push = accept && (cmd.has_a || cmd.has_b || cmd.has_end);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_TEXT;
            octal_reg <= 8'h00;
            error_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            octal_reg <= octal_next;
            error_reg <= error_next;
        end
    end

endmodule

// ----- hw/rtl/semu8_fifo.sv -----
module semu8_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  semu8_pkg::cmd_t push_cmd,
    input  logic            pop,
    output semu8_pkg::cmd_t head,
    output logic            empty,
    output logic            full
);

    semu8_pkg::cmd_t                mem_reg [semu8_pkg::FIFO_DEPTH];
    logic [semu8_pkg::FIFO_AW-1:0]  wr_reg, wr_next;
    logic [semu8_pkg::FIFO_AW-1:0]  rd_reg, rd_next;
    logic [semu8_pkg::FIFO_AW:0]    count_reg, count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (semu8_pkg::FIFO_AW+1)'(semu8_pkg::FIFO_DEPTH));
    assign head  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next    = push ? wr_reg + 1'b1 : wr_reg;
        rd_next    = pop ? rd_reg + 1'b1 : rd_reg;
        count_next = count_reg + {{semu8_pkg::FIFO_AW{1'b0}}, push}
                               - {{semu8_pkg::FIFO_AW{1'b0}}, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg    <= '0;
            rd_reg    <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_reg    <= wr_next;
            rd_reg    <= rd_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- hw/rtl/semu8_back.sv -----
module semu8_back (
    input  logic            clk,
    input  logic            rst_n,
    input  semu8_pkg::cmd_t head,
    input  logic            empty,
    output logic            pop,
    semu8_byte_if.source    bytes
);

    semu8_pkg::enc_t enc_a, enc_b;
    logic [1:0] len_a, len_b;
    logic [2:0] sum_ab, total;
    logic [2:0] idx_reg, idx_next;
    logic [2:0] off_b;
    logic       load;
    logic       at_last;
    logic [7:0] sel_byte;
    logic       sel_end;

    logic       valid_reg, valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       end_reg, end_next;
    logic       bad_reg, bad_next;
    logic       last_reg, last_next;

    function automatic logic [7:0] pick(input semu8_pkg::enc_t e, input logic [1:0] i);
        logic [7:0] b;
        unique case (i)
            2'd0:    b = e.b0;
            2'd1:    b = e.b1;
            default: b = e.b2;
        endcase
        return b;
    endfunction

    assign enc_a   = semu8_pkg::encode(head.char_a);
    assign enc_b   = semu8_pkg::encode(head.char_b);
    assign len_a   = head.has_a ? enc_a.len : 2'd0;
    assign len_b   = head.has_b ? enc_b.len : 2'd0;
    assign sum_ab  = {1'b0, len_a} + {1'b0, len_b};
    assign total   = sum_ab + {2'b00, head.has_end};
    assign off_b   = idx_reg - {1'b0, len_a};
    assign at_last = ((idx_reg + 3'd1) == total);
    assign load    = !empty && (!valid_reg || bytes.ready);
    assign pop     = load && at_last;

    always_comb
    begin
        sel_end = 1'b0;
        priority if (idx_reg < {1'b0, len_a})
        begin
            sel_byte = pick(enc_a, idx_reg[1:0]);
        end
        else if (idx_reg < sum_ab)
        begin
            sel_byte = pick(enc_b, off_b[1:0]);
        end
        else
        begin
            sel_byte = 8'h00;
            sel_end  = 1'b1;
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        end_next   = end_reg;
        bad_next   = bad_reg;
        last_next  = last_reg;
        if (bytes.ready)
        begin
            valid_next = 1'b0;
        end
        if (load)
        begin
            valid_next = 1'b1;
            byte_next  = sel_byte;
            end_next   = sel_end;
            bad_next   = sel_end && head.bad;
            last_next  = at_last;
            idx_next   = at_last ? 3'd0 : idx_reg + 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        end_reg  <= end_next;
        bad_reg  <= bad_next;
        last_reg <= last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    assign bytes.valid    = valid_reg;
    assign bytes.out_byte = byte_reg;
    assign bytes.is_end   = end_reg;
    assign bytes.is_bad   = bad_reg;
    assign bytes.run_last = last_reg;

endmodule

// ----- hw/rtl/string_escape_to_modified_utf8_core.sv -----
// Path: an accepted beat is written into the command queue, then from the queue head into
// the output register. Throughput: one unit beat per cycle into a four-entry command queue
// while not full; the byte sequencer sends one result per cycle unless the output stalls;
// a character gives one to three bytes and a command at most six. Reset: rst_n clears the
// escape state, queue pointers and output valid at once; the block is ready out of reset.
module string_escape_to_modified_utf8_core (
    input  logic         clk,
    input  logic         rst_n,
    semu8_unit_if.sink   units,
    semu8_byte_if.source bytes
);

    semu8_pkg::cmd_t push_cmd;
    semu8_pkg::cmd_t head;
    logic            push;
    logic            pop;
    logic            empty;
    logic            full;

    semu8_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .units (units),
        .full  (full),
        .push  (push),
        .cmd   (push_cmd)
    );

    semu8_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    semu8_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .head  (head),
        .empty (empty),
        .pop   (pop),
        .bytes (bytes)
    );

endmodule
